@@ src/u8e_pkg.sv @@
// Shared types, constants and the code point to byte encoding function.
package u8e_pkg;

   // Number of byte cells in the chain (longest UTF-8 sequence)
   localparam int NUM_CELLS = 4;
   localparam int IDX_W     = $clog2(NUM_CELLS);

   // Range limits for 1, 2, 3 and 4 byte sequences
   localparam logic [31:0] LIM_1B = 32'h0000_007F;
   localparam logic [31:0] LIM_2B = 32'h0000_07FF;
   localparam logic [31:0] LIM_3B = 32'h0000_FFFF;
   localparam logic [31:0] LIM_4B = 32'h0010_FFFF;

   // Lead and continuation byte markers
   localparam logic [7:0] LEAD_2B = 8'hC0;
   localparam logic [7:0] LEAD_3B = 8'hE0;
   localparam logic [7:0] LEAD_4B = 8'hF0;
   localparam logic [7:0] CONT_B  = 8'h80;

   // One byte slot of the chain
   typedef struct packed {
      logic             valid;
      logic [7:0]       out_byte;
      logic [IDX_W-1:0] byte_index;
      logic             last;
      logic             invalid;
   } cell_type;

   typedef cell_type [NUM_CELLS-1:0] chain_type;

   // Per-cell control
   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctrl_type;

   // Continuation byte from six payload bits
   function automatic logic [7:0] cont_byte(input logic [5:0] bits);
      return CONT_B | {2'b00, bits};
   endfunction

   // Build a valid, non-error slot
   function automatic cell_type mk_cell(input logic [7:0] b, input logic [IDX_W-1:0] idx,
                                        input logic fin);
      cell_type c;
      c.valid      = 1'b1;
      c.out_byte   = b;
      c.byte_index = idx;
      c.last       = fin;
      c.invalid    = 1'b0;
      return c;
   endfunction

   // Encode one code point into up to four slots, slot 0 first
   function automatic chain_type encode(input logic [31:0] cp);
      chain_type ch;
      ch = '0;
      if (cp <= LIM_1B) begin
         ch[0] = mk_cell(cp[7:0], IDX_W'(0), 1'b1);
      end else if (cp <= LIM_2B) begin
         ch[0] = mk_cell(LEAD_2B | {3'b000, cp[10:6]}, IDX_W'(0), 1'b0);
         ch[1] = mk_cell(cont_byte(cp[5:0]), IDX_W'(1), 1'b1);
      end else if (cp <= LIM_3B) begin
         ch[0] = mk_cell(LEAD_3B | {4'b0000, cp[15:12]}, IDX_W'(0), 1'b0);
         ch[1] = mk_cell(cont_byte(cp[11:6]), IDX_W'(1), 1'b0);
         ch[2] = mk_cell(cont_byte(cp[5:0]), IDX_W'(2), 1'b1);
      end else if (cp <= LIM_4B) begin
         ch[0] = mk_cell(LEAD_4B | {5'b00000, cp[20:18]}, IDX_W'(0), 1'b0);
         ch[1] = mk_cell(cont_byte(cp[17:12]), IDX_W'(1), 1'b0);
         ch[2] = mk_cell(cont_byte(cp[11:6]), IDX_W'(2), 1'b0);
         ch[3] = mk_cell(cont_byte(cp[5:0]), IDX_W'(3), 1'b1);
      end else begin
         // out of range: single error slot
         ch[0].valid   = 1'b1;
         ch[0].last    = 1'b1;
         ch[0].invalid = 1'b1;
      end
      return ch;
   endfunction

endpackage

@@ src/u8e_cell.sv @@
// One byte cell of the output chain: loads in parallel or takes its neighbor's byte.
module u8e_cell
   import u8e_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  cell_type      load_data,
   input  cell_type      nbr_data,
   output cell_type      cell_data
);

   cell_type cell_ff;
   cell_type cell_in;

   // Parallel load wins over shift
   always_comb begin
      cell_in = cell_ff;
      if (ctrl.load) begin
         cell_in = load_data;
      end else if (ctrl.shift) begin
         cell_in = nbr_data;
      end
   end

   // Reset empties the cell
   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff <= '0;
      end else begin
         cell_ff <= cell_in;
      end
   end

   assign cell_data = cell_ff;

endmodule

@@ src/utf8_code_point_encoder.sv @@
// Top level: UTF-8 encoder with an input holding stage and a four-cell byte chain.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  req     | req_valid, req_stall, req_code_point    | in
//  rsp     | rsp_valid, rsp_stall, rsp_out_byte,     | out
//          | rsp_byte_index, rsp_last, rsp_invalid   |
//
// An item gives 1 to 4 output bytes (one error byte for an out-of-range value);
// the chain sets the rate: one byte to rsp per cycle while rsp_stall is low.
// The next item waits encoded in the holding stage and loads into the chain in the
// cycle the last byte of the current one transfers, so bytes flow without gaps.
// Reset clears the valid bits of the holding stage and of every cell.
// rsp_stall freezes the chain; req_stall rises only while the holding stage is full.
module utf8_code_point_encoder
   import u8e_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [31:0]      req_code_point,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [7:0]       rsp_out_byte,
   output logic [IDX_W-1:0] rsp_byte_index,
   output logic             rsp_last,
   output logic             rsp_invalid
);

   chain_type     hold_ff;
   chain_type     hold_in;
   logic          hold_valid_ff;
   logic          hold_valid_in;
   chain_type     chain;
   cell_ctrl_type ctrl;
   logic          req_xfer;
   logic          rsp_xfer;

   // Chain control: shift on each byte transfer, reload when the chain drains
   assign rsp_xfer   = chain[0].valid && !rsp_stall;
   assign ctrl.shift = rsp_xfer;
   assign ctrl.load  = hold_valid_ff && (!chain[0].valid || (rsp_xfer && chain[0].last));

   // Input side
   assign req_stall = hold_valid_ff && !ctrl.load;
   assign req_xfer  = req_valid && !req_stall;

   // Holding stage: encode on transfer
   always_comb begin
      hold_in       = hold_ff;
      hold_valid_in = hold_valid_ff;
      if (req_xfer) begin
         hold_in       = encode(req_code_point);
         hold_valid_in = 1'b1;
      end else if (ctrl.load) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   // Chain of byte cells, cell 0 drives rsp
   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      cell_type nbr;
      if (i == NUM_CELLS - 1) begin : g_end
         assign nbr = '0;
      end else begin : g_mid
         assign nbr = chain[i+1];
      end
      u8e_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .load_data (hold_ff[i]),
         .nbr_data  (nbr),
         .cell_data (chain[i])
      );
   end

   assign rsp_valid      = chain[0].valid;
   assign rsp_out_byte   = chain[0].out_byte;
   assign rsp_byte_index = chain[0].byte_index;
   assign rsp_last       = chain[0].last;
   assign rsp_invalid    = chain[0].invalid;

   // Valid bytes sit packed at the head of the chain
   for (genvar j = 0; j < NUM_CELLS - 1; j++) begin : g_chk
      a_packed: assert property (@(posedge clock) disable iff (reset)
         chain[j+1].valid |-> chain[j].valid)
         else $error("chain has a gap before cell %0d", j + 1);
   end

   // Error result is a lone zero byte
   a_err_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_invalid) |-> (rsp_last && rsp_out_byte == 8'h00
                                      && rsp_byte_index == '0))
      else $error("malformed error result");

   // After a non-final byte the next byte follows at the next index
   a_idx_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_xfer && !rsp_last) |=> (rsp_valid
                                   && rsp_byte_index == $past(rsp_byte_index) + 1'b1))
      else $error("byte sequence broken");

   // A new item never overwrites a pending one
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      req_xfer |-> (!hold_valid_ff || ctrl.load))
      else $error("holding stage overrun");

endmodule
